// ----- hdl/ctl_pkg.sv -----
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and code tables for the C-like token lexer
// Token kinds, error codes, lexer states and character tables.
// ----------------------------------------------------------------------------
package ctl_pkg;

	localparam int unsigned DefPositionBits = 16;
	localparam logic [30:0] ValMax = 31'h7FFF_FFFF;
	localparam logic [13:0] KwAll  = 14'h3FFF;

	localparam logic [5:0] K_IDENT   = 6'd0;
	localparam logic [5:0] K_KEYWORD = 6'd1;
	localparam logic [5:0] K_INT     = 6'd2;
	localparam logic [5:0] K_REAL    = 6'd3;
	localparam logic [5:0] K_STRING  = 6'd4;
	localparam logic [5:0] K_END     = 6'd5;
	localparam logic [5:0] K_ERROR   = 6'd52;
	localparam logic [5:0] K_SBYTE   = 6'd53;

	localparam logic [3:0] E_NONE     = 4'd0;
	localparam logic [3:0] E_ILLEGAL  = 4'd1;
	localparam logic [3:0] E_OCTAL    = 4'd2;
	localparam logic [3:0] E_HEX      = 4'd3;
	localparam logic [3:0] E_REAL     = 4'd4;
	localparam logic [3:0] E_EMPTY    = 4'd5;
	localparam logic [3:0] E_OPEN     = 4'd6;
	localparam logic [3:0] E_MULTI    = 4'd7;
	localparam logic [3:0] E_OPEN_STR = 4'd8;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_ZERO, S_HEX0, S_HEXD, S_OCT, S_DEC, S_RDOT, S_RFRAC,
		S_CH_OPEN, S_CH_ESC, S_CH_OCT, S_CH_X0, S_CH_X1, S_CH_CLOSE,
		S_STR, S_ST_ESC, S_ST_OCT, S_ST_X0, S_ST_X1, S_OP
	} lex_state_t;

	// One result item.
	typedef struct packed {
		logic [5:0]  token_kind;
		logic [3:0]  keyword_index;
		logic [30:0] int_value;
		logic [7:0]  text_byte;
		logic [15:0] start_line;
		logic [15:0] start_col;
		logic [15:0] length;
		logic [3:0]  error_code;
	} tok_t;

	// Keyword character at position pos (0 past the end).
	function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [3:0] pos);
		logic [8*10-1:0] s;
		logic [7:0] r;
		begin
			unique case (idx)
				4'd0:  s = {"true",      48'h0};
				4'd1:  s = {"false",     40'h0};
				4'd2:  s = {"var",       56'h0};
				4'd3:  s = {"if",        64'h0};
				4'd4:  s = {"else",      48'h0};
				4'd5:  s = {"elif",      48'h0};
				4'd6:  s = {"while",     40'h0};
				4'd7:  s = {"do",        64'h0};
				4'd8:  s = {"for",       56'h0};
				4'd9:  s = {"break",     40'h0};
				4'd10: s = {"continue",  16'h0};
				4'd11: s = {"return",    32'h0};
				4'd12: s = {"procedure", 8'h0};
				4'd13: s = {"eval",      48'h0};
				default: s = '0;
			endcase
			r = 8'd0;
			for (int k = 0; k < 10; k++)
				if (pos == 4'(k)) r = s[8*(9-k) +: 8];
			return r;
		end
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] idx);
		unique case (idx)
			4'd0, 4'd4, 4'd5, 4'd13:  return 4'd4;
			4'd1, 4'd6, 4'd9:         return 4'd5;
			4'd2, 4'd8:               return 4'd3;
			4'd3, 4'd7:               return 4'd2;
			4'd10:                    return 4'd8;
			4'd11:                    return 4'd6;
			4'd12:                    return 4'd9;
			default:                  return 4'd0;
		endcase
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Hex digit value, 16 for a non-digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (is_digit(c)) return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
		return 5'd16;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] c);
		case (c)
			"a": return 8'd7;
			"b": return 8'd8;
			"f": return 8'd12;
			"n": return 8'd10;
			"r": return 8'd13;
			"t": return 8'd9;
			"v": return 8'd11;
			default: return c;
		endcase
	endfunction

	// Single-character punctuation; 63 for none.
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		unique case (c)
			"{": return 6'd6;
			"}": return 6'd7;
			"(": return 6'd8;
			")": return 6'd9;
			"[": return 6'd10;
			"]": return 6'd11;
			".": return 6'd12;
			"~": return 6'd15;
			"?": return 6'd48;
			":": return 6'd49;
			",": return 6'd50;
			";": return 6'd51;
			default: return 6'd63;
		endcase
	endfunction

	// Operator that may grow; 63 for none.
	function automatic logic [5:0] open_kind(input logic [7:0] c);
		unique case (c)
			"!": return 6'd13;
			"*": return 6'd16;
			"/": return 6'd18;
			"%": return 6'd20;
			"+": return 6'd22;
			"-": return 6'd25;
			">": return 6'd28;
			"<": return 6'd34;
			"=": return 6'd38;
			"&": return 6'd40;
			"^": return 6'd43;
			"|": return 6'd45;
			default: return 6'd63;
		endcase
	endfunction

	// Grown operator kind; 63 when c does not extend k.
	function automatic logic [5:0] op_extend(input logic [5:0] k, input logic [7:0] c);
		logic eq;
		begin
			eq = (c == "=");
			case (k)
				6'd13: return eq ? 6'd14 : 6'd63;
				6'd16: return eq ? 6'd17 : 6'd63;
				6'd18: return eq ? 6'd19 : 6'd63;
				6'd20: return eq ? 6'd21 : 6'd63;
				6'd22: return c == "+" ? 6'd23 : (eq ? 6'd24 : 6'd63);
				6'd25: return c == "-" ? 6'd26 : (eq ? 6'd27 : 6'd63);
				6'd28: return c == ">" ? 6'd29 : (eq ? 6'd33 : 6'd63);
				6'd29: return c == ">" ? 6'd30 : (eq ? 6'd32 : 6'd63);
				6'd30: return eq ? 6'd31 : 6'd63;
				6'd34: return c == "<" ? 6'd35 : (eq ? 6'd37 : 6'd63);
				6'd35: return eq ? 6'd36 : 6'd63;
				6'd38: return eq ? 6'd39 : 6'd63;
				6'd40: return c == "&" ? 6'd41 : (eq ? 6'd42 : 6'd63);
				6'd43: return eq ? 6'd44 : 6'd63;
				6'd45: return c == "|" ? 6'd46 : (eq ? 6'd47 : 6'd63);
				default: return 6'd63;
			endcase
		end
	endfunction

	function automatic logic can_extend(input logic [5:0] k);
		case (k)
			6'd13, 6'd16, 6'd18, 6'd20, 6'd22, 6'd25, 6'd28, 6'd29, 6'd30,
			6'd34, 6'd35, 6'd38, 6'd40, 6'd43, 6'd45: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

endpackage

// ----- hdl/c_like_token_lexer.sv -----
// ----------------------------------------------------------------------------
// c_like_token_lexer: byte-serial lexer for a small C-like language
// Turns a stream of source bytes into token transfers with positions.
// ----------------------------------------------------------------------------
// The lexer takes one source byte (or an end-of-input mark) per transfer and
// sustains one transfer per clock. Each byte is decoded against the held
// lexer state by one shallow combinational step; a byte that ends a token
// without belonging to it is decoded a second time in the same cycle, so one
// input transfer yields zero, one or two tokens. Those go into a two-entry
// output buffer; input is taken whenever that buffer will be empty after
// this cycle's pop, which lets a byte enter every cycle while the sink keeps
// up. A byte that yields two tokens holds off the next byte until its
// second token has drained, which is later if the sink stalls. The first
// token of a transfer is registered and shows in the cycle after it.
// After an error token the lexer drops every input until reset.
module c_like_token_lexer
	import ctl_pkg::*;
#(
	parameter int unsigned POSITION_BITS = DefPositionBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // kind: 0 byte, 1 end of input
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] token_kind, [9:6] keyword_index, [40:10] int_value,
	// [48:41] text_byte, [64:49] start_line, [80:65] start_col,
	// [96:81] length, [100:97] error_code, [103:101] zero
	output logic [103:0] m_tdata,
	output logic        m_tlast
);

	localparam int unsigned PB = POSITION_BITS;
	localparam logic [PB-1:0] PosMax = '1;
	localparam logic [PB-1:0] PosOne = PB'(1);

	// lexer state
	lex_state_t    st_q;
	logic [5:0]    pend_q;
	logic [13:0]   kwc_q;
	logic [30:0]   lit_q;
	logic [7:0]    esc_q;
	logic [1:0]    escn_q;
	logic [PB-1:0] line_q, col_q, tline_q, tcol_q, tlen_q;
	logic          halted_q;

	// output buffer: two entries, head first
	tok_t          buf_q [2];
	logic [1:0]    buf_last_q;
	logic [1:0]    cnt_q;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v != PosMax) ? v + PosOne : v;
	endfunction

	function automatic logic [30:0] acc(input logic [30:0] v, input logic [4:0] base,
		input logic [3:0] d);
		logic [36:0] t;
		begin
			t = 37'(v) * 37'(base) + 37'(d);
			return (t > 37'(ValMax)) ? ValMax : t[30:0];
		end
	endfunction

	// Working copy of the state that one decode step updates.
	typedef struct packed {
		lex_state_t    st;
		logic [5:0]    pend;
		logic [13:0]   kwc;
		logic [30:0]   lit;
		logic [7:0]    esc;
		logic [1:0]    escn;
		logic [PB-1:0] tline;
		logic [PB-1:0] tcol;
		logic [PB-1:0] tlen;
		logic          halted;
	} lstate_t;

	typedef struct packed {
		lstate_t nx;
		logic    emit;
		tok_t    tok;
		logic    replay;
	} step_t;

	function automatic tok_t mk(input logic [5:0] k, input logic [3:0] kwi,
		input logic [30:0] v, input logic [7:0] b, input logic [PB-1:0] ln,
		input logic [PB-1:0] cl, input logic [PB-1:0] len, input logic [3:0] e);
		tok_t t;
		begin
			t.token_kind = k; t.keyword_index = kwi; t.int_value = v; t.text_byte = b;
			t.start_line = 16'(ln); t.start_col = 16'(cl); t.length = 16'(len);
			t.error_code = e;
			return t;
		end
	endfunction

	function automatic step_t lex_step(input lstate_t s, input logic eof,
		input logic [7:0] c, input logic [PB-1:0] ln, input logic [PB-1:0] cl);
		step_t r;
		logic in_str;
		logic [4:0] h;
		logic [5:0] k;
		logic [3:0] ki;
		logic kfound;
		logic [7:0] byte_v;
		logic [7:0] ev;
		begin
			r.nx = s; r.emit = 1'b0; r.replay = 1'b0;
			r.tok = mk(6'd0, 4'd0, 31'd0, 8'd0, '0, '0, '0, E_NONE);
			in_str = (s.st == S_ST_ESC || s.st == S_ST_OCT || s.st == S_ST_X0 ||
				s.st == S_ST_X1);
			h = eof ? 5'd16 : hex_val(c);
			byte_v = 8'd0;
			ev = 8'd0;
			k = 6'd63;
			ki = 4'd0;
			kfound = 1'b0;
			unique case (s.st)
				S_IDLE: begin
					if (eof) begin
						r.emit = 1'b1; r.tok = mk(K_END, '0, '0, '0, ln, cl, '0, E_NONE);
					end else if (!is_blank(c)) begin
						r.nx.tline = ln; r.nx.tcol = cl; r.nx.tlen = PosOne; r.nx.lit = '0;
						if (is_alpha(c)) begin
							for (int i = 0; i < 14; i++)
								r.nx.kwc[i] = (kw_char(4'(i), 4'd0) == c);
							r.nx.st = S_IDENT;
						end else if (c == "0") begin
							r.nx.st = S_ZERO;
						end else if (is_digit(c)) begin
							r.nx.lit = 31'(c - "0"); r.nx.st = S_DEC;
						end else if (c == 8'h27) begin
							r.nx.st = S_CH_OPEN;
						end else if (c == 8'h22) begin
							r.nx.st = S_STR;
						end else if (single_kind(c) != 6'd63) begin
							r.emit = 1'b1;
							r.tok = mk(single_kind(c), '0, '0, '0, ln, cl, PosOne, E_NONE);
						end else if (open_kind(c) != 6'd63) begin
							r.nx.pend = open_kind(c); r.nx.st = S_OP;
						end else begin
							r.emit = 1'b1; r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_ILLEGAL);
							r.nx.halted = 1'b1;
						end
					end
				end
				S_IDENT: begin
					if (!eof && (is_alpha(c) || is_digit(c))) begin
						for (int i = 0; i < 14; i++)
							if (!(s.tlen < PB'(kw_len(4'(i))) &&
								kw_char(4'(i), s.tlen[3:0]) == c))
								r.nx.kwc[i] = 1'b0;
						r.nx.tlen = sat_inc(s.tlen);
					end else begin
						for (int i = 13; i >= 0; i--)
							if (s.kwc[i] && PB'(kw_len(4'(i))) == s.tlen) begin
								kfound = 1'b1; ki = 4'(i);
							end
						r.emit = 1'b1;
						r.tok = mk(kfound ? K_KEYWORD : K_IDENT, ki, '0, '0, s.tline, s.tcol,
							s.tlen, E_NONE);
						r.nx.kwc = KwAll; r.nx.st = S_IDLE; r.replay = 1'b1;
					end
				end
				S_ZERO: begin
					if (!eof && (c == "x" || c == "X")) begin
						r.nx.tlen = sat_inc(s.tlen); r.nx.st = S_HEX0;
					end else if (!eof && is_digit(c)) begin
						if (c >= "8") begin
							r.emit = 1'b1; r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_OCTAL);
							r.nx.halted = 1'b1; r.nx.st = S_IDLE;
						end else begin
							r.nx.lit = 31'(c - "0"); r.nx.tlen = sat_inc(s.tlen);
							r.nx.st = S_OCT;
						end
					end else begin
						r.emit = 1'b1;
						r.tok = mk(K_INT, '0, '0, '0, s.tline, s.tcol, s.tlen, E_NONE);
						r.nx.st = S_IDLE; r.replay = 1'b1;
					end
				end
				S_HEX0: begin
					if (h < 5'd16) begin
						r.nx.lit = 31'(h); r.nx.tlen = sat_inc(s.tlen); r.nx.st = S_HEXD;
					end else begin
						r.emit = 1'b1; r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_HEX);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end
				end
				S_HEXD, S_OCT, S_DEC: begin
					if (s.st == S_HEXD && h < 5'd16) begin
						r.nx.lit = acc(s.lit, 5'd16, h[3:0]); r.nx.tlen = sat_inc(s.tlen);
					end else if (s.st == S_OCT && !eof && is_digit(c) && c >= "8") begin
						r.emit = 1'b1; r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_OCTAL);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end else if (s.st != S_HEXD && !eof && is_digit(c)) begin
						r.nx.lit = acc(s.lit, (s.st == S_OCT) ? 5'd8 : 5'd10, h[3:0]);
						r.nx.tlen = sat_inc(s.tlen);
					end else if (s.st == S_DEC && !eof && c == ".") begin
						r.nx.tlen = sat_inc(s.tlen); r.nx.st = S_RDOT;
					end else begin
						r.emit = 1'b1;
						r.tok = mk(K_INT, '0, s.lit, '0, s.tline, s.tcol, s.tlen, E_NONE);
						r.nx.st = S_IDLE; r.replay = 1'b1;
					end
				end
				S_RDOT: begin
					if (!eof && is_digit(c)) begin
						r.nx.tlen = sat_inc(s.tlen); r.nx.st = S_RFRAC;
					end else begin
						r.emit = 1'b1; r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_REAL);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end
				end
				S_RFRAC: begin
					if (!eof && is_digit(c)) begin
						r.nx.tlen = sat_inc(s.tlen);
					end else begin
						r.emit = 1'b1;
						r.tok = mk(K_REAL, '0, '0, '0, s.tline, s.tcol, s.tlen, E_NONE);
						r.nx.st = S_IDLE; r.replay = 1'b1;
					end
				end
				S_CH_OPEN: begin
					if (eof || c == 8'h27) begin
						r.emit = 1'b1;
						r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, eof ? E_OPEN : E_EMPTY);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end else begin
						r.nx.tlen = sat_inc(s.tlen);
						if (c == 8'h5C) r.nx.st = S_CH_ESC;
						else begin
							r.nx.lit = 31'(c); r.nx.st = S_CH_CLOSE;
						end
					end
				end
				S_CH_CLOSE: begin
					if (!eof && c == 8'h27) begin
						r.emit = 1'b1;
						r.tok = mk(K_INT, '0, s.lit, '0, s.tline, s.tcol, sat_inc(s.tlen),
							E_NONE);
						r.nx.tlen = sat_inc(s.tlen); r.nx.st = S_IDLE;
					end else begin
						r.emit = 1'b1;
						r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, eof ? E_OPEN : E_MULTI);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end
				end
				S_STR: begin
					if (eof) begin
						r.emit = 1'b1;
						r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0, E_OPEN_STR);
						r.nx.halted = 1'b1; r.nx.st = S_IDLE;
					end else begin
						r.nx.tlen = sat_inc(s.tlen);
						if (c == 8'h22) begin
							r.emit = 1'b1;
							r.tok = mk(K_STRING, '0, '0, '0, s.tline, s.tcol, sat_inc(s.tlen),
								E_NONE);
							r.nx.st = S_IDLE;
						end else if (c == 8'h5C) begin
							r.nx.st = S_ST_ESC;
						end else begin
							r.emit = 1'b1;
							r.tok = mk(K_SBYTE, '0, '0, c, s.tline, s.tcol, '0, E_NONE);
						end
					end
				end
				S_OP: begin
					k = eof ? 6'd63 : op_extend(s.pend, c);
					if (k != 6'd63) begin
						r.nx.tlen = sat_inc(s.tlen);
						if (can_extend(k)) r.nx.pend = k;
						else begin
							r.emit = 1'b1;
							r.tok = mk(k, '0, '0, '0, s.tline, s.tcol, sat_inc(s.tlen), E_NONE);
							r.nx.st = S_IDLE;
						end
					end else begin
						r.emit = 1'b1;
						r.tok = mk(s.pend, '0, '0, '0, s.tline, s.tcol, s.tlen, E_NONE);
						r.nx.st = S_IDLE; r.replay = 1'b1;
					end
				end
				default: begin
					// escape states of character and string literals
					if (s.st == S_CH_ESC || s.st == S_ST_ESC) begin
						if (eof) begin
							r.emit = 1'b1;
							r.tok = mk(K_ERROR, '0, '0, '0, ln, cl, '0,
								in_str ? E_OPEN_STR : E_OPEN);
							r.nx.halted = 1'b1; r.nx.st = S_IDLE;
						end else begin
							r.nx.tlen = sat_inc(s.tlen);
							if (c >= "0" && c <= "7") begin
								r.nx.esc = 8'(c - "0"); r.nx.escn = 2'd1;
								r.nx.st = in_str ? S_ST_OCT : S_CH_OCT;
							end else if (c == "x") begin
								r.nx.st = in_str ? S_ST_X0 : S_CH_X0;
							end else begin
								r.emit = in_str; byte_v = simple_escape(c);
								r.nx.st = S_CH_CLOSE;
							end
						end
					end else if (s.st == S_CH_OCT || s.st == S_ST_OCT) begin
						if (!eof && c >= "0" && c <= "7" && s.escn < 2'd3) begin
							ev = {s.esc[4:0], c[2:0]};
							r.nx.esc = ev; r.nx.escn = s.escn + 2'd1;
							r.nx.tlen = sat_inc(s.tlen);
							if (s.escn == 2'd2) begin
								r.emit = in_str; byte_v = ev; r.nx.st = S_CH_CLOSE;
							end
						end else begin
							r.emit = in_str; byte_v = s.esc; r.nx.st = S_CH_CLOSE;
							r.replay = 1'b1;
						end
					end else if (s.st == S_CH_X0 || s.st == S_ST_X0) begin
						if (h < 5'd16) begin
							r.nx.esc = 8'(h); r.nx.escn = 2'd1; r.nx.tlen = sat_inc(s.tlen);
							r.nx.st = in_str ? S_ST_X1 : S_CH_X1;
						end else begin
							r.emit = in_str; byte_v = "x"; r.nx.st = S_CH_CLOSE;
							r.replay = 1'b1;
						end
					end else begin
						if (h < 5'd16) begin
							ev = {s.esc[3:0], h[3:0]};
							r.nx.esc = ev; r.nx.escn = 2'd2; r.nx.tlen = sat_inc(s.tlen);
							r.emit = in_str; byte_v = ev; r.nx.st = S_CH_CLOSE;
						end else begin
							r.emit = in_str; byte_v = s.esc; r.nx.st = S_CH_CLOSE;
							r.replay = 1'b1;
						end
					end
					// hand the decoded byte to the string or to the character literal
					if (r.nx.st == S_CH_CLOSE) begin
						if (in_str) begin
							r.nx.st = S_STR;
							r.tok = mk(K_SBYTE, '0, '0, byte_v, s.tline, s.tcol, '0, E_NONE);
						end else begin
							r.nx.lit = 31'(byte_v);
						end
					end
				end
			endcase
			return r;
		end
	endfunction

	lstate_t cur;
	step_t   p1, p2;
	lstate_t nxt;
	logic    take;
	logic    pop;
	logic    load;
	logic [1:0] n_new;
	tok_t    t0, t1;
	logic [1:0] cnt_left;

	always_comb begin
		cur = '{st: st_q, pend: pend_q, kwc: kwc_q, lit: lit_q, esc: esc_q, escn: escn_q,
			tline: tline_q, tcol: tcol_q, tlen: tlen_q, halted: halted_q};
		p1 = lex_step(cur, s_tuser, s_tdata, line_q, col_q);
		p2 = lex_step(p1.nx, s_tuser, s_tdata, line_q, col_q);
		if (p1.replay && !p1.nx.halted) begin
			nxt = p2.nx;
			n_new = 2'(p1.emit) + 2'(p2.emit);
			t0 = p1.emit ? p1.tok : p2.tok;
			t1 = p2.tok;
		end else begin
			nxt = p1.nx;
			n_new = 2'(p1.emit);
			t0 = p1.tok;
			t1 = p2.tok;
		end
	end

	// Accept when the buffer can hold two more tokens after this cycle's pop.
	assign pop      = m_tvalid && m_tready;
	assign cnt_left = cnt_q - 2'(pop);
	assign s_tready = (cnt_left == 2'd0);
	assign take     = s_tvalid && s_tready;
	assign load     = take && !halted_q;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {3'd0, buf_q[0].error_code, buf_q[0].length, buf_q[0].start_col,
		buf_q[0].start_line, buf_q[0].text_byte, buf_q[0].int_value,
		buf_q[0].keyword_index, buf_q[0].token_kind};
	assign m_tlast  = buf_last_q[0];

	// Token payload: load this transfer's tokens, else advance the head.
	always_ff @(posedge clk) begin
		if (load && n_new != 2'd0) begin
			buf_q[0] <= t0;
			if (n_new == 2'd2) buf_q[1] <= t1;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pend_q <= '0;
			kwc_q <= KwAll;
			lit_q <= '0;
			esc_q <= '0;
			escn_q <= '0;
			line_q <= PosOne;
			col_q <= PosOne;
			tline_q <= PosOne;
			tcol_q <= PosOne;
			tlen_q <= '0;
			halted_q <= 1'b0;
			cnt_q <= '0;
			buf_last_q <= '0;
		end else begin
			if (load) begin
				st_q <= nxt.st;
				pend_q <= nxt.pend;
				kwc_q <= nxt.kwc;
				lit_q <= nxt.lit;
				esc_q <= nxt.esc;
				escn_q <= nxt.escn;
				tline_q <= nxt.tline;
				tcol_q <= nxt.tcol;
				tlen_q <= nxt.tlen;
				halted_q <= nxt.halted;
				if (!s_tuser) begin
					if (s_tdata == 8'h0A) begin
						line_q <= sat_inc(line_q);
						col_q <= PosOne;
					end else begin
						col_q <= sat_inc(col_q);
					end
				end
			end
			// buffer is empty after pop when taking
			if (load && n_new != 2'd0) begin
				buf_last_q[0] <= (n_new == 2'd1);
				if (n_new == 2'd2) buf_last_q[1] <= 1'b1;
			end else if (pop) begin
				buf_last_q[0] <= buf_last_q[1];
			end
			cnt_q <= load ? n_new : cnt_left;
		end
	end

`ifndef SYNTH
	// Buffer never overfills.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("token buffer overflow");
	// A halted lexer yields no new tokens.
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && cnt_q == 2'd0) |=> cnt_q == 2'd0) else $error("tokens after halt");
	// Error tokens close an item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5:0] == K_ERROR) |-> m_tlast) else $error("error not last");
	// Once halted, stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt cleared");
`endif

endmodule
